/* rtl/core/oetr_pkg.sv */
// ----------------------------------------------------------------------------
// oetr_pkg
// shared types and constants of the overwriting event trace ring
// ----------------------------------------------------------------------------
package oetr_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;
    localparam int UNREAD_W    = 8;
    localparam int LIMIT_W     = 16;
    localparam int WIDE_W      = 17;

    typedef struct packed {
        logic [63:0] seq_number;
        logic [63:0] timestamp;
        logic [31:0] event_type;
        logic [31:0] event_flags;
        logic [7:0]  cpu_index;
        logic [63:0] process_id;
        logic [63:0] thread_id;
        logic [63:0] argument_a;
        logic [63:0] argument_b;
        logic [63:0] argument_c;
        logic [63:0] argument_d;
    } t_record;

    localparam int REC_W = $bits(t_record);

    typedef struct packed {
        logic issue;
        logic snap_done;
    } t_back_stat;

endpackage

/* rtl/core/oetr_ram.sv */
// ----------------------------------------------------------------------------
// oetr_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module oetr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/oetr_queue.sv */
// ----------------------------------------------------------------------------
// oetr_queue
// two entry descriptor queue between front and back
// ----------------------------------------------------------------------------
module oetr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_fill, n_fill;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/core/oetr_front.sv */
// ----------------------------------------------------------------------------
// oetr_front
// accepts words, writes appended records, builds read descriptors
// ----------------------------------------------------------------------------
module oetr_front import oetr_pkg::*; #(
    parameter int RING_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic [63:0]                   i_timestamp,
    input  logic [31:0]                   i_event_type,
    input  logic [31:0]                   i_event_flags,
    input  logic [7:0]                    i_cpu_index,
    input  logic [63:0]                   i_process_id,
    input  logic [63:0]                   i_thread_id,
    input  logic [63:0]                   i_argument_a,
    input  logic [63:0]                   i_argument_b,
    input  logic [63:0]                   i_argument_c,
    input  logic [63:0]                   i_argument_d,
    input  logic [LIMIT_W-1:0]            i_snapshot_limit,
    output logic                          o_we,
    output logic [$clog2(RING_DEPTH)-1:0] o_waddr,
    output t_record                       o_wdata,
    output logic                          o_q_valid,
    input  logic                          i_q_ready,
    output logic [$clog2(RING_DEPTH)+CNT_W:0] o_q_data,
    input  t_back_stat                    i_stat
);

    localparam int AW = $clog2(RING_DEPTH);

    logic [AW-1:0]       r_wp, n_wp;
    logic [AW:0]         r_count, n_count;
    logic [63:0]         r_seq, n_seq;
    logic [UNREAD_W-1:0] r_unread, n_unread;
    logic [1:0]          r_snap_cnt, n_snap_cnt;

    logic                w_acc;
    logic                w_room;
    logic [WIDE_W-1:0]   w_cnt;
    logic [WIDE_W-1:0]   w_lim;
    logic [WIDE_W-1:0]   w_min;
    logic [CNT_W-1:0]    w_n;
    logic [WIDE_W-1:0]   w_wp;
    logic [WIDE_W-1:0]   w_nx;
    logic [WIDE_W-1:0]   w_start;
    logic [AW-1:0]       w_slot;
    logic [CNT_W-1:0]    w_len;
    logic                w_enq;

    assign w_room = (r_snap_cnt == 2'd0)
                 && (32'(r_unread) < 32'(RING_DEPTH));
    assign o_ready = i_q_ready && (i_command || w_room);
    assign w_acc   = i_valid && o_ready;

    // clamp snapshot length to count, limit and result ceiling
    always_comb begin
        w_cnt = WIDE_W'(r_count);
        w_lim = WIDE_W'(i_snapshot_limit);
        w_min = (w_lim < w_cnt) ? w_lim : w_cnt;
        w_n   = (w_min > WIDE_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : w_min[CNT_W-1:0];
        w_wp  = WIDE_W'(r_wp);
        w_nx  = WIDE_W'(w_n);
        w_start = (w_wp >= w_nx) ? (w_wp - w_nx) : (w_wp + WIDE_W'(RING_DEPTH) - w_nx);
    end

    assign w_slot = i_command ? w_start[AW-1:0] : r_wp;
    assign w_len  = i_command ? w_n : CNT_W'(1);
    assign w_enq  = w_acc && (!i_command || (w_n != '0));

    assign o_q_valid = w_enq;
    assign o_q_data  = {i_command, w_slot, w_len};

    assign o_we    = w_acc && !i_command;
    assign o_waddr = r_wp;

    always_comb begin
        o_wdata.seq_number  = r_seq;
        o_wdata.timestamp   = i_timestamp;
        o_wdata.event_type  = i_event_type;
        o_wdata.event_flags = i_event_flags;
        o_wdata.cpu_index   = i_cpu_index;
        o_wdata.process_id  = i_process_id;
        o_wdata.thread_id   = i_thread_id;
        o_wdata.argument_a  = i_argument_a;
        o_wdata.argument_b  = i_argument_b;
        o_wdata.argument_c  = i_argument_c;
        o_wdata.argument_d  = i_argument_d;
    end

    always_comb begin
        n_wp    = r_wp;
        n_count = r_count;
        n_seq   = r_seq;
        if (o_we) begin
            n_wp  = (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            n_seq = r_seq + 64'd1;
            if (r_count != (AW+1)'(RING_DEPTH)) begin
                n_count = r_count + (AW+1)'(1);
            end
        end
        n_unread = r_unread
                 + (w_enq ? UNREAD_W'(w_len) : '0)
                 - UNREAD_W'(i_stat.issue);
        n_snap_cnt = r_snap_cnt
                   + {1'b0, w_enq && i_command}
                   - {1'b0, i_stat.snap_done};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_count    <= '0;
            r_seq      <= 64'd1;
            r_unread   <= '0;
            r_snap_cnt <= '0;
        end else begin
            r_wp       <= n_wp;
            r_count    <= n_count;
            r_seq      <= n_seq;
            r_unread   <= n_unread;
            r_snap_cnt <= n_snap_cnt;
        end
    end

endmodule

/* rtl/core/oetr_back.sv */
// ----------------------------------------------------------------------------
// oetr_back
// walks read descriptors, one ram read per cycle unless the output is stalled, drives output word valid
// ----------------------------------------------------------------------------
module oetr_back import oetr_pkg::*; #(
    parameter int RING_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    output logic                              o_q_ready,
    input  logic [$clog2(RING_DEPTH)+CNT_W:0] i_q_data,
    output logic                              o_re,
    output logic [$clog2(RING_DEPTH)-1:0]     o_raddr,
    output t_back_stat                        o_stat,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_last
);

    localparam int AW = $clog2(RING_DEPTH);

    logic             r_cur_vld, n_cur_vld;
    logic             r_snap, n_snap;
    logic [AW-1:0]    r_slot, n_slot;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_rd_vld, n_rd_vld;
    logic             r_rd_last, n_rd_last;

    logic             d_snap;
    logic [AW-1:0]    d_slot;
    logic [CNT_W-1:0] d_len;
    logic             w_issue;
    logic             w_finish;
    logic             w_pop;

    assign {d_snap, d_slot, d_len} = i_q_data;

    assign w_issue   = r_cur_vld && (!r_rd_vld || i_ready);
    assign w_finish  = w_issue && (r_left == CNT_W'(1));
    assign w_pop     = i_q_valid && (!r_cur_vld || w_finish);
    assign o_q_ready = !r_cur_vld || w_finish;

    assign o_re    = w_issue;
    assign o_raddr = r_slot;
    assign o_stat.issue     = w_issue;
    assign o_stat.snap_done = w_finish && r_snap;
    assign o_valid = r_rd_vld;
    assign o_last  = r_rd_last;

    always_comb begin
        n_cur_vld = r_cur_vld;
        n_snap    = r_snap;
        n_slot    = r_slot;
        n_left    = r_left;
        if (w_pop) begin
            n_cur_vld = 1'b1;
            n_snap    = d_snap;
            n_slot    = d_slot;
            n_left    = d_len;
        end else if (w_finish) begin
            n_cur_vld = 1'b0;
        end else if (w_issue) begin
            n_slot = (r_slot == AW'(RING_DEPTH - 1)) ? '0 : r_slot + AW'(1);
            n_left = r_left - CNT_W'(1);
        end
        n_rd_vld  = r_rd_vld;
        n_rd_last = r_rd_last;
        if (w_issue) begin
            n_rd_vld  = 1'b1;
            n_rd_last = (r_left == CNT_W'(1));
        end else if (i_ready) begin
            n_rd_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_cur_vld <= n_cur_vld;
            r_rd_vld  <= n_rd_vld;
            r_rd_last <= n_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
        r_slot <= n_slot;
        r_left <= n_left;
    end

endmodule

/* rtl/core/overwriting_event_trace_ring_top.sv */
// ----------------------------------------------------------------------------
// overwriting_event_trace_ring_top
// Event trace ring that keeps the newest RING_DEPTH records. An append word
// (command 0) stores a record stamped with a running 64-bit sequence number
// starting at 1 and returns it as one output word with last_record set; when
// the ring is full the oldest record is overwritten. A snapshot word
// (command 1) returns the newest min(count, snapshot_limit, 64) records,
// oldest first, last_record on the final one; an empty snapshot returns none.
// Both channels are valid/ready. Appends are taken one per cycle while the
// queue has room and no snapshot is pending; a snapshot of n records
// streams one word per cycle while the receiver is ready, set by the single
// record ram read port, and appends that follow it wait until its last read
// has been issued. Snapshots queue freely behind it. A two entry descriptor
// queue separates input acceptance from ram reads, and the ram read register
// is the output stage, so a stalled receiver holds the current word and
// backs up the queue before input ready drops. Reset empties the ring,
// restarts the sequence at 1 and drops all pending output words.
// ----------------------------------------------------------------------------
module overwriting_event_trace_ring_top import oetr_pkg::*; #(
    parameter int RING_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [63:0]        i_timestamp,
    input  logic [31:0]        i_event_type,
    input  logic [31:0]        i_event_flags,
    input  logic [7:0]         i_cpu_index,
    input  logic [63:0]        i_process_id,
    input  logic [63:0]        i_thread_id,
    input  logic [63:0]        i_argument_a,
    input  logic [63:0]        i_argument_b,
    input  logic [63:0]        i_argument_c,
    input  logic [63:0]        i_argument_d,
    input  logic [LIMIT_W-1:0] i_snapshot_limit,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [63:0]        o_seq_number,
    output logic [63:0]        o_out_timestamp,
    output logic [31:0]        o_out_type,
    output logic [31:0]        o_out_flags,
    output logic [7:0]         o_out_cpu,
    output logic [63:0]        o_out_process,
    output logic [63:0]        o_out_thread,
    output logic [63:0]        o_out_arg_a,
    output logic [63:0]        o_out_arg_b,
    output logic [63:0]        o_out_arg_c,
    output logic [63:0]        o_out_arg_d,
    output logic               o_last_record
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int DW = 1 + AW + CNT_W;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_record       w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    t_record       w_rdata;
    logic          w_fq_valid;
    logic          w_fq_ready;
    logic [DW-1:0] w_fq_data;
    logic          w_qb_valid;
    logic          w_qb_ready;
    logic [DW-1:0] w_qb_data;
    t_back_stat    w_stat;

    oetr_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_timestamp      (i_timestamp),
        .i_event_type     (i_event_type),
        .i_event_flags    (i_event_flags),
        .i_cpu_index      (i_cpu_index),
        .i_process_id     (i_process_id),
        .i_thread_id      (i_thread_id),
        .i_argument_a     (i_argument_a),
        .i_argument_b     (i_argument_b),
        .i_argument_c     (i_argument_c),
        .i_argument_d     (i_argument_d),
        .i_snapshot_limit (i_snapshot_limit),
        .o_we             (w_we),
        .o_waddr          (w_waddr),
        .o_wdata          (w_wdata),
        .o_q_valid        (w_fq_valid),
        .i_q_ready        (w_fq_ready),
        .o_q_data         (w_fq_data),
        .i_stat           (w_stat)
    );

    oetr_queue #(
        .WIDTH (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_data  (w_fq_data),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready),
        .o_data  (w_qb_data)
    );

    oetr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qb_valid),
        .o_q_ready (w_qb_ready),
        .i_q_data  (w_qb_data),
        .o_re      (w_re),
        .o_raddr   (w_raddr),
        .o_stat    (w_stat),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_last    (o_last_record)
    );

    oetr_ram #(
        .WIDTH (REC_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_seq_number    = w_rdata.seq_number;
    assign o_out_timestamp = w_rdata.timestamp;
    assign o_out_type      = w_rdata.event_type;
    assign o_out_flags     = w_rdata.event_flags;
    assign o_out_cpu       = w_rdata.cpu_index;
    assign o_out_process   = w_rdata.process_id;
    assign o_out_thread    = w_rdata.thread_id;
    assign o_out_arg_a     = w_rdata.argument_a;
    assign o_out_arg_b     = w_rdata.argument_b;
    assign o_out_arg_c     = w_rdata.argument_c;
    assign o_out_arg_d     = w_rdata.argument_d;

endmodule

/* sim/tb_overwriting_event_trace_ring_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_overwriting_event_trace_ring_top
// Drives append and snapshot words into the trace ring with bursty input and
// a stalling receiver. A bench copy of the ring predicts the untyped output words.
// The opening table checks the empty and extreme cases against typed-in
// values. The random part then fills and wraps the ring, overwrites old
// records and runs snapshots longer than one output run. Each output word is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_overwriting_event_trace_ring_top;
    import oetr_pkg::*;

    localparam int   RING_DEPTH   = 256;
    localparam int   N_DIRECTED   = 18;
    localparam int   N_RANDOM     = 290;
    localparam int   HOLD_CYCLES  = 80;
    localparam logic CMD_APPEND   = 1'b0;
    localparam logic CMD_SNAPSHOT = 1'b1;

    typedef struct packed {
        logic        cmd;
        t_record     ev;
        logic [15:0] limit;
    } t_cmd_word;

    typedef struct packed {
        t_record rec;
        logic    last;
    } t_trace_word;

    typedef struct packed {
        logic        cmd;
        logic [63:0] fill;
        logic [15:0] limit;
        logic        typed;
        logic [63:0] exp_seq;
    } t_dir_row;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} t_rx_mode;

    // typed rows: appends carry their sequence number, snapshots expect nothing
    localparam t_dir_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{CMD_SNAPSHOT, 64'h0,                  16'hFFFF, 1'b1, 64'd0},
        '{CMD_SNAPSHOT, 64'h0,                  16'h0000, 1'b1, 64'd0},
        '{CMD_APPEND,   64'h0,                  16'h0000, 1'b1, 64'd1},
        '{CMD_APPEND,   64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 64'd2},
        '{CMD_SNAPSHOT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b1, 64'd0},
        '{CMD_SNAPSHOT, 64'h0,                  16'h0001, 1'b0, 64'd0},
        '{CMD_SNAPSHOT, 64'h0,                  16'hFFFF, 1'b0, 64'd0},
        '{CMD_APPEND,   64'hA5A5_A5A5_A5A5_A5A5, 16'h5A5A, 1'b1, 64'd3},
        '{CMD_APPEND,   64'h5A5A_5A5A_5A5A_5A5A, 16'hA5A5, 1'b1, 64'd4},
        '{CMD_APPEND,   64'h0123_4567_89AB_CDEF, 16'h0000, 1'b1, 64'd5},
        '{CMD_SNAPSHOT, 64'h0,                  16'h0002, 1'b0, 64'd0},
        '{CMD_SNAPSHOT, 64'h0,                  16'h0005, 1'b0, 64'd0},
        '{CMD_SNAPSHOT, 64'h0,                  16'h0006, 1'b0, 64'd0},
        '{CMD_SNAPSHOT, 64'h0,                  16'h8000, 1'b0, 64'd0},
        '{CMD_APPEND,   64'hFEDC_BA98_7654_3210, 16'h0000, 1'b1, 64'd6},
        '{CMD_SNAPSHOT, 64'h0,                  16'h0040, 1'b0, 64'd0},
        '{CMD_APPEND,   64'h8000_0000_0000_0001, 16'hFFFF, 1'b1, 64'd7},
        '{CMD_SNAPSHOT, 64'h0,                  16'hFFFF, 1'b0, 64'd0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_command;
    logic [63:0]         i_timestamp;
    logic [31:0]         i_event_type;
    logic [31:0]         i_event_flags;
    logic [7:0]          i_cpu_index;
    logic [63:0]         i_process_id;
    logic [63:0]         i_thread_id;
    logic [63:0]         i_argument_a;
    logic [63:0]         i_argument_b;
    logic [63:0]         i_argument_c;
    logic [63:0]         i_argument_d;
    logic [LIMIT_W-1:0]  i_snapshot_limit;
    logic                o_valid;
    logic                i_ready;
    logic [63:0]         o_seq_number;
    logic [63:0]         o_out_timestamp;
    logic [31:0]         o_out_type;
    logic [31:0]         o_out_flags;
    logic [7:0]          o_out_cpu;
    logic [63:0]         o_out_process;
    logic [63:0]         o_out_thread;
    logic [63:0]         o_out_arg_a;
    logic [63:0]         o_out_arg_b;
    logic [63:0]         o_out_arg_c;
    logic [63:0]         o_out_arg_d;
    logic                o_last_record;

    t_record     ring_rec [RING_DEPTH];
    int          ring_wp;
    int          ring_count;
    logic [63:0] ring_next_seq;
    t_trace_word expected_q [$];
    int          mismatch_count = 0;
    int          words_seen = 0;
    int          burst_left = 1;

    overwriting_event_trace_ring_top #(
        .RING_DEPTH (RING_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_timestamp      (i_timestamp),
        .i_event_type     (i_event_type),
        .i_event_flags    (i_event_flags),
        .i_cpu_index      (i_cpu_index),
        .i_process_id     (i_process_id),
        .i_thread_id      (i_thread_id),
        .i_argument_a     (i_argument_a),
        .i_argument_b     (i_argument_b),
        .i_argument_c     (i_argument_c),
        .i_argument_d     (i_argument_d),
        .i_snapshot_limit (i_snapshot_limit),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_seq_number     (o_seq_number),
        .o_out_timestamp  (o_out_timestamp),
        .o_out_type       (o_out_type),
        .o_out_flags      (o_out_flags),
        .o_out_cpu        (o_out_cpu),
        .o_out_process    (o_out_process),
        .o_out_thread     (o_out_thread),
        .o_out_arg_a      (o_out_arg_a),
        .o_out_arg_b      (o_out_arg_b),
        .o_out_arg_c      (o_out_arg_c),
        .o_out_arg_d      (o_out_arg_d),
        .o_last_record    (o_last_record)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // bench copy of the ring: updates state and, when keep is set, queues the words it emits
    task automatic ring_apply(input t_cmd_word w, input bit keep);
        int          n;
        int          start;
        int          i;
        t_trace_word e;
        if (w.cmd == CMD_APPEND) begin
            ring_rec[ring_wp] = w.ev;
            ring_rec[ring_wp].seq_number = ring_next_seq;
            if (keep) begin
                e.rec  = ring_rec[ring_wp];
                e.last = 1'b1;
                expected_q.push_back(e);
            end
            ring_next_seq = ring_next_seq + 64'd1;
            ring_wp = (ring_wp + 1) % RING_DEPTH;
            if (ring_count < RING_DEPTH) ring_count++;
        end else begin
            n = ring_count;
            if (int'(w.limit) < n) n = int'(w.limit);
            if (n > MAX_RESULTS) n = MAX_RESULTS;
            start = (ring_wp - n + RING_DEPTH) % RING_DEPTH;
            for (i = 0; i < n; i++) begin
                e.rec  = ring_rec[(start + i) % RING_DEPTH];
                e.last = (i == n - 1);
                if (keep) expected_q.push_back(e);
            end
        end
    endtask

    // called at a rising edge; returns at the edge that accepted the word, or after the input gap that follows it
    task automatic offer_word(input t_cmd_word w, input bit typed,
                              input logic [63:0] typed_seq);
        int          gap;
        t_trace_word e;
        i_valid          <= 1'b1;
        i_command        <= w.cmd;
        i_timestamp      <= w.ev.timestamp;
        i_event_type     <= w.ev.event_type;
        i_event_flags    <= w.ev.event_flags;
        i_cpu_index      <= w.ev.cpu_index;
        i_process_id     <= w.ev.process_id;
        i_thread_id      <= w.ev.thread_id;
        i_argument_a     <= w.ev.argument_a;
        i_argument_b     <= w.ev.argument_b;
        i_argument_c     <= w.ev.argument_c;
        i_argument_d     <= w.ev.argument_d;
        i_snapshot_limit <= w.limit;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        ring_apply(w, !typed);
        if (typed && w.cmd == CMD_APPEND) begin
            e.rec            = w.ev;
            e.rec.seq_number = typed_seq;
            e.last           = 1'b1;
            expected_q.push_back(e);
        end
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin : stimulus
        t_cmd_word   w;
        logic [63:0] f;
        int          r;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_command        <= CMD_APPEND;
        i_timestamp      <= '0;
        i_event_type     <= '0;
        i_event_flags    <= '0;
        i_cpu_index      <= '0;
        i_process_id     <= '0;
        i_thread_id      <= '0;
        i_argument_a     <= '0;
        i_argument_b     <= '0;
        i_argument_c     <= '0;
        i_argument_d     <= '0;
        i_snapshot_limit <= '0;
        ring_wp       = 0;
        ring_count    = 0;
        ring_next_seq = 64'd1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < N_DIRECTED; r++) begin
            f = DIRECTED_ROWS[r].fill;
            w.cmd              = DIRECTED_ROWS[r].cmd;
            w.limit            = DIRECTED_ROWS[r].limit;
            w.ev.seq_number    = '0;
            w.ev.timestamp     = f;
            w.ev.event_type    = f[31:0];
            w.ev.event_flags   = f[63:32];
            w.ev.cpu_index     = f[7:0];
            w.ev.process_id    = f;
            w.ev.thread_id     = f;
            w.ev.argument_a    = f;
            w.ev.argument_b    = f;
            w.ev.argument_c    = f;
            w.ev.argument_d    = f;
            offer_word(w, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp_seq);
        end

        // mostly appends so the ring fills, wraps and overwrites
        for (r = 0; r < N_RANDOM; r++) begin
            w.cmd = (r % 18 == 17 || $urandom_range(0, 23) == 0) ? CMD_SNAPSHOT : CMD_APPEND;
            w.ev.seq_number  = '0;
            w.ev.timestamp   = {$urandom, $urandom};
            w.ev.event_type  = $urandom;
            w.ev.event_flags = $urandom;
            w.ev.cpu_index   = 8'($urandom);
            w.ev.process_id  = {$urandom, $urandom};
            w.ev.thread_id   = {$urandom, $urandom};
            w.ev.argument_a  = {$urandom, $urandom};
            w.ev.argument_b  = {$urandom, $urandom};
            w.ev.argument_c  = {$urandom, $urandom};
            w.ev.argument_d  = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: w.limit = 16'd0;
                1: w.limit = 16'($urandom_range(1, 8));
                2: w.limit = 16'($urandom_range(60, 70));
                3: w.limit = 16'hFFFF;
                4: w.limit = 16'($urandom_range(200, 300));
                default: w.limit = 16'($urandom);
            endcase
            offer_word(w, 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_overwriting_event_trace_ring_top passed");
        end else begin
            $display("tb_overwriting_event_trace_ring_top failed");
        end
        $finish;
    end

    initial begin : rx_pacing
        t_rx_mode mode;
        int       phase_left;
        int       hold;
        bit       held;
        i_ready <= 1'b0;
        mode       = RX_OPEN;
        phase_left = 0;
        held       = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            // one long hold-off so the block backs up and drops input ready
            if (!held && words_seen >= 150) begin
                held = 1'b1;
                i_ready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge i_clk);
            end
            if (phase_left == 0) begin
                mode       = t_rx_mode'($urandom_range(0, 2));
                phase_left = $urandom_range(8, 40);
            end
            phase_left--;
            case (mode)
                RX_OPEN:   i_ready <= 1'b1;
                RX_RANDOM: i_ready <= 1'($urandom_range(0, 1));
                default:   i_ready <= (phase_left % 4 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : word_check
        t_trace_word e;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            words_seen <= words_seen + 1;
            if (expected_q.size() == 0) begin
                report_mismatch("word with nothing expected", o_seq_number, '0);
            end else begin
                e = expected_q.pop_front();
                if (o_seq_number !== e.rec.seq_number)
                    report_mismatch("seq_number", o_seq_number, e.rec.seq_number);
                if (o_out_timestamp !== e.rec.timestamp)
                    report_mismatch("out_timestamp", o_out_timestamp, e.rec.timestamp);
                if (o_out_type !== e.rec.event_type)
                    report_mismatch("out_type", 64'(o_out_type), 64'(e.rec.event_type));
                if (o_out_flags !== e.rec.event_flags)
                    report_mismatch("out_flags", 64'(o_out_flags), 64'(e.rec.event_flags));
                if (o_out_cpu !== e.rec.cpu_index)
                    report_mismatch("out_cpu", 64'(o_out_cpu), 64'(e.rec.cpu_index));
                if (o_out_process !== e.rec.process_id)
                    report_mismatch("out_process", o_out_process, e.rec.process_id);
                if (o_out_thread !== e.rec.thread_id)
                    report_mismatch("out_thread", o_out_thread, e.rec.thread_id);
                if (o_out_arg_a !== e.rec.argument_a)
                    report_mismatch("out_arg_a", o_out_arg_a, e.rec.argument_a);
                if (o_out_arg_b !== e.rec.argument_b)
                    report_mismatch("out_arg_b", o_out_arg_b, e.rec.argument_b);
                if (o_out_arg_c !== e.rec.argument_c)
                    report_mismatch("out_arg_c", o_out_arg_c, e.rec.argument_c);
                if (o_out_arg_d !== e.rec.argument_d)
                    report_mismatch("out_arg_d", o_out_arg_d, e.rec.argument_d);
                if (o_last_record !== e.last)
                    report_mismatch("last_record", 64'(o_last_record), 64'(e.last));
            end
        end
    end

    initial begin : run_limit
        #20000000;
        $display("tb_overwriting_event_trace_ring_top failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/oetr_pkg.sv
rtl/core/oetr_ram.sv
rtl/core/oetr_queue.sv
rtl/core/oetr_front.sv
rtl/core/oetr_back.sv
rtl/core/overwriting_event_trace_ring_top.sv
sim/tb_overwriting_event_trace_ring_top.sv
